/* design/btid_pkg.sv */
// shared types, constants and helpers of the bitmap to id list decoder
package btid_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int POS_BITS    = 3;
    localparam int ID_BITS     = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [BYTE_BITS-1:0] byte_t;
    typedef logic [POS_BITS-1:0]  pos_t;
    typedef logic [ID_BITS-1:0]   id_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    // position of the first set bit counted from bit 7, 0 when none
    function automatic pos_t first_set_pos(input byte_t bits);
        pos_t pos;
        pos = '0;
        for (int i = 0; i < BYTE_BITS; i++)
        begin
            if (bits[i])
            begin
                pos = pos_t'(BYTE_BITS - 1 - i);
            end
        end
        return pos;
    endfunction

endpackage

/* design/bitmap_to_id_list_decoder_core.sv */
// top level of the bitmap to id list decoder
// Each accepted bitmap byte yields one id per set bit, MSB first, as
// base_value + byte_index*8 + (7 - bit), wrapping at 2^32; an empty final byte
// yields a single result with has_value low that closes the set. The front end
// takes one byte per cycle while its 2-entry queue has room; empty inner bytes
// never enter the queue. The back end sends one result per cycle while out_stall
// is low, so a byte with n set bits yields n results (one for an empty final
// byte), up to 8, and that back-end expansion sets the sustained rate. The user
// must write base_value only while the block is idle; the block does not enforce it.
module bitmap_to_id_list_decoder_core #(
    parameter int INDEX_BITS = 29
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  btid_pkg::id_t       cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  btid_pkg::byte_t     bitmap_byte,
    input  logic                last_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output btid_pkg::id_t       id_value,
    output logic                has_value,
    output logic                byte_done,
    output logic                set_done
);
    import btid_pkg::*;

    localparam int ENTRY_BITS = BYTE_BITS + 1 + INDEX_BITS;

    id_t                   base_value_reg;
    queue_status_t         q_status;
    logic                  push;
    byte_t                 push_bits;
    logic                  push_last;
    logic [INDEX_BITS-1:0] push_index;
    logic                  pop;
    logic [ENTRY_BITS-1:0] pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_value_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            base_value_reg <= cfg_wr_data;
        end
    end

    btid_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .bitmap_byte (bitmap_byte),
        .last_byte   (last_byte),
        .q_status    (q_status),
        .push        (push),
        .push_bits   (push_bits),
        .push_last   (push_last),
        .push_index  (push_index)
    );

    btid_queue #(
        .DATA_BITS (ENTRY_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_bits, push_last, push_index}),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    btid_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .base_value (base_value_reg),
        .q_valid    (q_status.valid),
        .q_bits     (pop_data[ENTRY_BITS-1 -: BYTE_BITS]),
        .q_last     (pop_data[INDEX_BITS]),
        .q_index    (pop_data[INDEX_BITS-1:0]),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .id_value   (id_value),
        .has_value  (has_value),
        .byte_done  (byte_done),
        .set_done   (set_done)
    );

endmodule

/* design/btid_front.sv */
// front end: accepts bitmap bytes, keeps the byte index, queues non-empty and final bytes
module btid_front #(
    parameter int INDEX_BITS = 29
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  btid_pkg::byte_t         bitmap_byte,
    input  logic                    last_byte,
    input  btid_pkg::queue_status_t q_status,
    output logic                    push,
    output btid_pkg::byte_t         push_bits,
    output logic                    push_last,
    output logic [INDEX_BITS-1:0]   push_index
);
    import btid_pkg::*;

    logic [INDEX_BITS-1:0] index_reg;
    logic [INDEX_BITS-1:0] index_next;
    logic                  accept;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    // empty inner bytes only advance the index
    assign push       = accept && ((bitmap_byte != '0) || last_byte);
    assign push_bits  = bitmap_byte;
    assign push_last  = last_byte;
    assign push_index = index_reg;

    always_comb
    begin
        index_next = index_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                index_next = '0;
            end
            else
            begin
                index_next = index_reg + INDEX_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
        end
        else
        begin
            index_reg <= index_next;
        end
    end

endmodule

/* design/btid_queue.sv */
// short queue between front end and back end
module btid_queue #(
    parameter int DATA_BITS = 38
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [DATA_BITS-1:0]    push_data,
    input  logic                    pop,
    output logic [DATA_BITS-1:0]    pop_data,
    output btid_pkg::queue_status_t status
);
    import btid_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_BITS-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign pop_data     = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        logic [PTR_BITS-1:0] r;
        if (p == PTR_BITS'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_BITS'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> status.valid)
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && status.full |-> pop)
        else $error("push into full queue");

endmodule

/* design/btid_back.sv */
// back end: expands one queued byte into id results, one per cycle while out_stall is low
module btid_back #(
    parameter int INDEX_BITS = 29
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  btid_pkg::id_t         base_value,
    input  logic                  q_valid,
    input  btid_pkg::byte_t       q_bits,
    input  logic                  q_last,
    input  logic [INDEX_BITS-1:0] q_index,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output btid_pkg::id_t         id_value,
    output logic                  has_value,
    output logic                  byte_done,
    output logic                  set_done
);
    import btid_pkg::*;

    logic                  busy_reg;
    byte_t                 bits_reg;
    logic                  last_reg;
    logic [INDEX_BITS-1:0] index_reg;

    logic                  out_valid_reg;
    id_t                   id_reg;
    logic                  has_reg;
    logic                  byte_done_reg;
    logic                  set_done_reg;

    logic                  advance;
    logic                  emit;
    pos_t                  pos;
    byte_t                 rest;
    logic                  final_result;
    id_t                   id_next;

    assign advance      = !out_valid_reg || !out_stall;
    assign emit         = busy_reg && advance;
    assign pos          = first_set_pos(bits_reg);
    assign rest         = bits_reg & ~(byte_t'(8'h80) >> pos);
    assign final_result = (rest == '0);
    assign id_next      = base_value + ID_BITS'({index_reg, pos});
    assign pop          = q_valid && (!busy_reg || (emit && final_result));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (emit && final_result)
            begin
                busy_reg <= 1'b0;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bits_reg  <= q_bits;
            last_reg  <= q_last;
            index_reg <= q_index;
        end
        else if (emit)
        begin
            bits_reg <= rest;
        end

        if (emit)
        begin
            // empty final byte marks the end of the set without a value
            id_reg        <= (bits_reg == '0) ? '0 : id_next;
            has_reg       <= (bits_reg != '0);
            byte_done_reg <= final_result;
            set_done_reg  <= final_result && last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign id_value  = id_reg;
    assign has_value = has_reg;
    assign byte_done = byte_done_reg;
    assign set_done  = set_done_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_value |-> set_done && byte_done)
        else $error("result without value must close the set");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && set_done |-> byte_done)
        else $error("set end without byte end");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !final_result && emit |=> busy_reg)
        else $error("byte dropped before its last result");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (bits_reg == '0) |-> last_reg)
        else $error("empty inner byte reached the back end");

endmodule

/* test/tb_bitmap_to_id_list_decoder_core.sv */
`timescale 1ns / 100ps
// self-checking testbench of the bitmap to id list decoder core
module tb_bitmap_to_id_list_decoder_core;
    import btid_pkg::*;

    localparam int INDEX_W         = 29;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int RANDOM_PHASES   = 6;
    localparam int BYTES_PER_PHASE = 52;

    typedef struct packed {
        id_t  id;
        logic has;
        logic bdone;
        logic sdone;
    } id_result_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    logic  clk         = 1'b0;
    logic  rst_n       = 1'b0;
    logic  cfg_wr_en   = 1'b0;
    id_t   cfg_wr_data = '0;
    logic  in_valid    = 1'b0;
    logic  in_stall;
    byte_t bitmap_byte = '0;
    logic  last_byte   = 1'b0;
    logic  out_valid;
    logic  out_stall   = 1'b0;
    id_t   id_value;
    logic  has_value;
    logic  byte_done;
    logic  set_done;

    id_t                base_model  = '0;
    logic [INDEX_W-1:0] index_model = '0;
    id_result_t         pending_ids[$];
    int                 err_count   = 0;
    int                 burst_left  = 0;
    logic               steady_send = 1'b0;
    logic               hold_req    = 1'b0;

    bitmap_to_id_list_decoder_core #(
        .INDEX_BITS(INDEX_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .bitmap_byte(bitmap_byte),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .id_value(id_value),
        .has_value(has_value),
        .byte_done(byte_done),
        .set_done(set_done)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // expected ids of one accepted item, msb first
    function automatic void expand_byte(input byte_t bits, input logic last);
        id_t        start;
        int         total;
        int         seen;
        id_result_t r;
        start = id_t'(index_model) * BYTE_BITS;
        total = $countones(bits);
        seen  = 0;
        if (bits == '0)
        begin
            if (last)
            begin
                r.id    = '0;
                r.has   = 1'b0;
                r.bdone = 1'b1;
                r.sdone = 1'b1;
                pending_ids.insert(pending_ids.size(), r);
            end
        end
        else
        begin
            for (int b = BYTE_BITS - 1; b >= 0; b--)
            begin
                if (bits[b])
                begin
                    seen++;
                    r.id    = base_model + start + id_t'(BYTE_BITS - 1 - b);
                    r.has   = 1'b1;
                    r.bdone = (seen == total);
                    r.sdone = (seen == total) && last;
                    pending_ids.insert(pending_ids.size(), r);
                end
            end
        end
        if (last)
            index_model = '0;
        else
            index_model = index_model + 1'b1;
    endfunction

    function automatic byte_t rand_bitmap();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            return '0;
        else if (sel == 2)
            return '1;
        else if (sel == 3)
            return byte_t'(1) << $urandom_range(0, BYTE_BITS - 1);
        else
            return byte_t'($urandom);
    endfunction

    // prediction on accepted items and config writes, then result checking
    initial
    begin
        id_result_t want;
        id_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (cfg_wr_en)
                    base_model = cfg_wr_data;
                if (in_valid && !in_stall)
                    expand_byte(bitmap_byte, last_byte);
                if (out_valid && !out_stall)
                begin
                    got.id    = id_value;
                    got.has   = has_value;
                    got.bdone = byte_done;
                    got.sdone = set_done;
                    if (pending_ids.size() == 0)
                    begin
                        $display("%0t: unexpected item id %h has %b byte_done %b set_done %b",
                                 $time, got.id, got.has, got.bdone, got.sdone);
                        err_count++;
                    end
                    else
                    begin
                        want = pending_ids[0];
                        pending_ids.delete(0);
                        if (got !== want)
                        begin
                            $display("%0t: mismatch expected id %h has %b byte_done %b set_done %b",
                                     $time, want.id, want.has, want.bdone, want.sdone);
                            $display("%0t:          actual   id %h has %b byte_done %b set_done %b",
                                     $time, got.id, got.has, got.bdone, got.sdone);
                            err_count++;
                        end
                    end
                end
            end
        end
    end

    // receiver stall pattern with an occasional long hold
    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        int          hold_left;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 4) != 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_byte(input byte_t bits, input logic last);
        int gap;
        in_valid    <= 1'b1;
        bitmap_byte <= bits;
        last_byte   <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!steady_send)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(0, 10);
            end
        end
    endtask

    task automatic send_set(input int len);
        for (int i = 0; i < len; i++)
            send_byte(rand_bitmap(), i == len - 1);
    endtask

    // drain expected ids, then let empty inner bytes settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_ids.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input id_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic test_directed();
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h80, 1'b1);
        wait_idle();
        write_base(32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h81, 1'b1);
        wait_idle();
        write_base(32'hFFFF_FFF9);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        wait_idle();
        write_base('0);
    endtask

    task automatic test_base_sweep();
        id_t bases[5];
        bases = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, id_t'($urandom)};
        foreach (bases[i])
        begin
            wait_idle();
            write_base(bases[i]);
            send_set(4);
            send_set(4);
        end
    endtask

    // long receiver hold while the sender keeps offering mostly full bytes
    task automatic test_backpressure();
        wait_idle();
        steady_send = 1'b1;
        hold_req    = 1'b1;
        for (int i = 0; i < 40; i++)
            send_byte((i % 5 == 4) ? rand_bitmap() : 8'hFF, (i % 8) == 7);
        steady_send = 1'b0;
    endtask

    task automatic test_random_sets();
        int sent;
        int len;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            case (p)
                0:       write_base('1);
                1:       write_base('0);
                default: write_base(id_t'($urandom));
            endcase
            sent = 0;
            while (sent < BYTES_PER_PHASE)
            begin
                len = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
                send_set(len);
                sent += len;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_base_sweep();
        test_backpressure();
        test_random_sets();
        wait_idle();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
